>>> design/gha_pkg.sv
// ---------------------------------------------------------------------------
// gha_pkg
// Shared constants and codes of the generational handle allocator.
// ---------------------------------------------------------------------------
package gha_pkg;

  localparam int HANDLE_W  = 32;
  localparam int TAG_W     = 16;
  localparam int HIDX_W    = 16;
  localparam int SLOT_OUT_W = 10;

  localparam logic [1:0] OP_ALLOCATE = 2'd0;
  localparam logic [1:0] OP_RELEASE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

>>> design/gha_req_if.sv
// ---------------------------------------------------------------------------
// gha_req_if
// Request channel: operation code and handle with valid/ready.
// ---------------------------------------------------------------------------
interface gha_req_if
  import gha_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, operation, handle, input ready);
  modport sink   (input valid, operation, handle, output ready);
endinterface

>>> design/gha_rsp_if.sv
// ---------------------------------------------------------------------------
// gha_rsp_if
// Response channel: status, issued handle and slot index with valid/ready.
// ---------------------------------------------------------------------------
interface gha_rsp_if
  import gha_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [HANDLE_W-1:0]   new_handle;
  logic [SLOT_OUT_W-1:0] slot_index;

  modport source (output valid, status, new_handle, slot_index, input ready);
  modport sink   (input valid, status, new_handle, slot_index, output ready);
endinterface

>>> design/generational_handle_allocator_unit.sv
// Flow: a request's tag and free-stack entries are read into registers when it
// is accepted; its response is registered when the execute state completes.
// No new request is taken until then; execute waits while a response is unread.
// Reset: counters and tag counter clear at once; memories are not cleared
// and need no clearing pass, entries are used only after being written.
// ---------------------------------------------------------------------------
// generational_handle_allocator_unit
// Allocates, releases and checks generation-tagged handles over a slot pool
// held in a tag memory and a free-index stack memory.
// ---------------------------------------------------------------------------
module generational_handle_allocator_unit
  import gha_pkg::*;
#(
  parameter int MAX_SLOTS = 1024
) (
  input  logic       clk,
  input  logic       rst,
  gha_req_if.sink    req,
  gha_rsp_if.source  rsp
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = HIDX_W + 1;

  logic [TAG_W-1:0] slot_tag   [MAX_SLOTS];
  logic [IDX_W-1:0] free_stack [MAX_SLOTS];

  state_t              state;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    used_slots;
  logic [TAG_W-1:0]    tag_counter;
  logic [1:0]          op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TAG_W-1:0]    tag_q;
  logic [IDX_W-1:0]    stk_q;

  logic                  out_valid;
  logic [1:0]            out_status;
  logic [HANDLE_W-1:0]   out_handle;
  logic [SLOT_OUT_W-1:0] out_slot;

  logic                req_xfer;
  logic                fire;
  logic [HIDX_W-1:0]   idx_in;
  logic [TAG_W-1:0]    tag_in;
  logic                hv;
  logic [TAG_W-1:0]    tag_inc;
  logic [TAG_W-1:0]    tag_new;
  logic                from_stack;
  logic                from_new;
  logic [IDX_W-1:0]    alloc_idx;
  logic [1:0]          res_status;
  logic [HANDLE_W-1:0] res_handle;
  logic [IDX_W-1:0]    res_idx;
  logic [HIDX_W-1:0]   res_idx16;
  logic [CNT_W-1:0]    stk_raddr;
  logic                tag_we;
  logic [IDX_W-1:0]    tag_waddr;
  logic [TAG_W-1:0]    tag_wdata;
  logic                stk_we;

  assign req.ready = (state == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign fire      = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign idx_in  = handle_q[HIDX_W-1:0];
  assign tag_in  = handle_q[HANDLE_W-1:HIDX_W];
  assign hv      = (CMP_W'(idx_in) < CMP_W'(used_slots)) &&
                   (CMP_W'(idx_in) < CMP_W'(MAX_SLOTS)) &&
                   (tag_in != '0) && (tag_q == tag_in);
  assign tag_inc = tag_counter + TAG_W'(1);
  assign tag_new = (tag_inc == '0) ? TAG_W'(1) : tag_inc;

  assign from_stack = (free_count != '0);
  assign from_new   = !from_stack && (used_slots < CNT_W'(MAX_SLOTS));
  assign alloc_idx  = from_stack ? stk_q : used_slots[IDX_W-1:0];
  assign stk_raddr  = free_count - CNT_W'(1);

  always_comb begin
    res_status = ST_INVALID;
    res_handle = '0;
    res_idx    = '0;
    tag_we     = 1'b0;
    tag_waddr  = alloc_idx;
    tag_wdata  = tag_new;
    stk_we     = 1'b0;
    case (op_q)
      OP_ALLOCATE: begin
        if (from_stack || from_new) begin
          res_status = ST_OK;
          res_idx    = alloc_idx;
          res_handle = {tag_new, HIDX_W'(alloc_idx)};
          tag_we     = fire;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (hv) begin
          res_status = ST_OK;
          res_idx    = idx_in[IDX_W-1:0];
          tag_we     = fire;
          tag_waddr  = idx_in[IDX_W-1:0];
          tag_wdata  = '0;
          stk_we     = fire && (free_count < CNT_W'(MAX_SLOTS));
        end
      end
      OP_LOOKUP: begin
        if (hv) begin
          res_status = ST_OK;
          res_idx    = idx_in[IDX_W-1:0];
        end
      end
      default: begin
        res_status = ST_INVALID;
      end
    endcase
  end

  assign res_idx16 = HIDX_W'(res_idx);

  // memories
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      tag_q <= slot_tag[req.handle[IDX_W-1:0]];
      stk_q <= free_stack[stk_raddr[IDX_W-1:0]];
    end
    if (tag_we) begin
      slot_tag[tag_waddr] <= tag_wdata;
    end
    if (stk_we) begin
      free_stack[free_count[IDX_W-1:0]] <= idx_in[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      op_q     <= req.operation;
      handle_q <= req.handle;
    end
    if (fire) begin
      out_status <= res_status;
      out_handle <= res_handle;
      out_slot   <= res_idx16[SLOT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_count  <= '0;
      used_slots  <= '0;
      tag_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            if (op_q == OP_ALLOCATE) begin
              if (from_stack) begin
                free_count  <= free_count - CNT_W'(1);
                tag_counter <= tag_new;
              end else if (from_new) begin
                used_slots  <= used_slots + CNT_W'(1);
                tag_counter <= tag_new;
              end
            end else if (op_q == OP_RELEASE && hv &&
                         free_count < CNT_W'(MAX_SLOTS)) begin
              free_count <= free_count + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.new_handle = out_handle;
  assign rsp.slot_index = out_slot;

  a_stack_within_used: assert property (@(posedge clk) disable iff (rst)
    free_count <= used_slots)
    else $error("free stack deeper than allocated slots");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_slots <= CNT_W'(MAX_SLOTS))
    else $error("high-water count beyond pool size");

  a_zero_tag_only_release: assert property (@(posedge clk) disable iff (rst)
    tag_we && (tag_wdata == '0) |-> (op_q == OP_RELEASE))
    else $error("zero tag written by an allocate");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid && (state == S_IDLE))
    else $error("completed request left no response");

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> (state == S_EXEC))
    else $error("accepted request not executed");

endmodule

>>> sim/generational_handle_allocator_unit_tb.sv
// ---------------------------------------------------------------------------
// generational_handle_allocator_unit_tb
// Drives allocate, release and lookup requests into the handle allocator and
// checks every response against a cycle-free model of the slot pool, tag
// counter and free stack. Covers a directed opening, random mixes, a long
// receiver hold-off, pool exhaustion and a partial drain.
// ---------------------------------------------------------------------------
module generational_handle_allocator_unit_tb;
  import gha_pkg::*;

  localparam int POOL_SLOTS = 1024;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]            status;
    logic [HANDLE_W-1:0]   new_handle;
    logic [SLOT_OUT_W-1:0] slot_index;
  } gha_resp_t;

  logic clk = 1'b0;
  logic rst;

  gha_req_if req ();
  gha_rsp_if rsp ();

  generational_handle_allocator_unit #(
    .MAX_SLOTS(POOL_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pool model
  logic [TAG_W-1:0]      tag_mem [POOL_SLOTS];
  logic [SLOT_OUT_W-1:0] free_mem [POOL_SLOTS];
  int unsigned           free_depth;
  int unsigned           high_water;
  logic [TAG_W-1:0]      tag_seq;

  logic [HANDLE_W-1:0] live_handles [$];
  logic [HANDLE_W-1:0] stale_handles [$];
  gha_resp_t           pending_responses [$];

  bit idle_on;
  int hold_requests;
  int errors;
  int tag_wraps;
  int n_requests, n_ok, n_full, n_invalid;

  function automatic bit slot_matches(input logic [15:0] idx, input logic [TAG_W-1:0] tag);
    return (idx < high_water) && (idx < POOL_SLOTS) && (tag != '0) &&
           (tag_mem[idx[SLOT_OUT_W-1:0]] == tag);
  endfunction

  function automatic gha_resp_t allocator_response(input logic [1:0] op,
                                                   input logic [HANDLE_W-1:0] h);
    gha_resp_t        r;
    logic [15:0]      idx;
    logic [TAG_W-1:0] tag;
    bit               got;
    r.status     = ST_INVALID;
    r.new_handle = '0;
    r.slot_index = '0;
    idx = h[15:0];
    tag = h[31:16];
    got = 1'b0;
    case (op)
      OP_ALLOCATE: begin
        if (free_depth > 0) begin
          free_depth--;
          idx = {6'd0, free_mem[free_depth]};
          got = 1'b1;
        end else if (high_water < POOL_SLOTS) begin
          idx = high_water[15:0];
          high_water++;
          got = 1'b1;
        end
        if (got) begin
          tag_seq = tag_seq + 16'd1;
          if (tag_seq == '0) begin
            tag_seq = 16'd1;
            tag_wraps++;
          end
          tag_mem[idx[SLOT_OUT_W-1:0]] = tag_seq;
          r.status     = ST_OK;
          r.new_handle = {tag_seq, idx};
          r.slot_index = idx[SLOT_OUT_W-1:0];
          live_handles.push_back(r.new_handle);
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (slot_matches(idx, tag)) begin
          if (free_depth < POOL_SLOTS) begin
            free_mem[free_depth] = idx[SLOT_OUT_W-1:0];
            free_depth++;
          end
          tag_mem[idx[SLOT_OUT_W-1:0]] = '0;
          r.status     = ST_OK;
          r.slot_index = idx[SLOT_OUT_W-1:0];
          for (int k = 0; k < live_handles.size(); k++) begin
            if (live_handles[k] == h) begin
              live_handles.delete(k);
              break;
            end
          end
          stale_handles.push_back(h);
          if (stale_handles.size() > 64) void'(stale_handles.pop_front());
        end
      end
      OP_LOOKUP: begin
        if (slot_matches(idx, tag)) begin
          r.status     = ST_OK;
          r.slot_index = idx[SLOT_OUT_W-1:0];
        end
      end
      default: ;
    endcase
    n_requests++;
    case (r.status)
      ST_OK:   n_ok++;
      ST_FULL: n_full++;
      default: n_invalid++;
    endcase
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_live();
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  // about half live handles, the rest stale, wrong tag, tag zero, aliased, beyond the high-water mark or noise
  function automatic logic [HANDLE_W-1:0] probe_handle();
    int                  kind;
    logic [HANDLE_W-1:0] h;
    kind = $urandom_range(0, 9);
    h = $urandom();
    if (kind <= 4 && live_handles.size() > 0) begin
      h = pick_live();
    end else if (kind == 5 && stale_handles.size() > 0) begin
      h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
    end else if (kind == 6 && live_handles.size() > 0) begin
      h = pick_live();
      h[31:16] = h[31:16] + 16'($urandom_range(1, 65535));
    end else if (kind == 7 && live_handles.size() > 0) begin
      h = pick_live();
      h[31:16] = '0;
    end else if (kind == 8 && live_handles.size() > 0) begin
      h = pick_live();
      h[15:10] = 6'($urandom_range(1, 63));
    end else if (kind == 9) begin
      h[15:0] = 16'($urandom_range(high_water, 65535));
    end
    return h;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [HANDLE_W-1:0] h);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid     = 1'b1;
    req.operation = op;
    req.handle    = h;
    do @(posedge clk); while (req.ready !== 1'b1);
    pending_responses.push_back(allocator_response(op, h));
  endtask

  task automatic note_mismatch(input string what, input gha_resp_t want, input gha_resp_t got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch (%s): expected %0d/%h/%0d, got %0d/%h/%0d",
               $realtime, what, want.status, want.new_handle, want.slot_index,
               got.status, got.new_handle, got.slot_index);
  endtask

  always @(posedge clk) begin
    gha_resp_t got;
    gha_resp_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got.status     = rsp.status;
      got.new_handle = rsp.new_handle;
      got.slot_index = rsp.slot_index;
      if (pending_responses.size() == 0) begin
        note_mismatch("unexpected transfer", '0, got);
      end else begin
        want = pending_responses.pop_front();
        if (got.status !== want.status || got.new_handle !== want.new_handle ||
            got.slot_index !== want.slot_index)
          note_mismatch("field", want, got);
      end
    end
  end

  // response side: random stalls and the long hold-off
  initial begin
    int stall;
    int hold_left;
    int hold_served;
    stall = 0;
    hold_left = 0;
    hold_served = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        rsp.ready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        rsp.ready = 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 3) - 1;
        rsp.ready = 1'b0;
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
    end
    $display("generational_handle_allocator_unit_tb failed");
    $finish;
  end

  task automatic test_directed();
    logic [HANDLE_W-1:0] first, second, third;
    send_request(OP_LOOKUP, 32'h0000_0000);
    send_request(OP_RELEASE, 32'hffff_ffff);
    send_request(OP_UNUSED, 32'h0001_0000);
    send_request(OP_ALLOCATE, 32'hffff_ffff);
    first = live_handles[$];
    send_request(OP_ALLOCATE, 32'h0000_0000);
    second = live_handles[$];
    send_request(OP_LOOKUP, first);
    send_request(OP_LOOKUP, second);
    send_request(OP_LOOKUP, {16'h0000, first[15:0]});
    send_request(OP_LOOKUP, {first[31:16] + 16'd1, first[15:0]});
    send_request(OP_RELEASE, {second[31:16], 16'd2});
    send_request(OP_LOOKUP, first | 32'h0000_0400);
    send_request(OP_LOOKUP, second | 32'h0000_8000);
    send_request(OP_RELEASE, first);
    send_request(OP_RELEASE, first);
    // released slot holds tag zero, a zero-tag handle must still miss
    send_request(OP_LOOKUP, {16'h0000, first[15:0]});
    send_request(OP_RELEASE, {16'h0000, first[15:0]});
    send_request(OP_ALLOCATE, 32'h5a5a_a5a5);
    third = live_handles[$];
    send_request(OP_LOOKUP, first);
    send_request(OP_LOOKUP, third);
    send_request(OP_RELEASE, second);
    send_request(OP_RELEASE, third);
    send_request(OP_ALLOCATE, 32'h0000_0000);
    send_request(OP_ALLOCATE, 32'h0000_0000);
    send_request(OP_UNUSED, 32'hffff_ffff);
  endtask

  task automatic test_random_mix(input int count);
    int                  pick;
    logic [1:0]          op;
    logic [HANDLE_W-1:0] h;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      h = probe_handle();
      if (pick < 8) begin
        op = OP_ALLOCATE;
        h = $urandom();
      end else if (pick < 13) begin
        op = OP_RELEASE;
      end else if (pick < 19) begin
        op = OP_LOOKUP;
      end else begin
        op = OP_UNUSED;
      end
      send_request(op, h);
    end
  endtask

  task automatic test_backpressure();
    hold_requests++;
    repeat (30) begin
      if ($urandom_range(0, 1) == 0) send_request(OP_ALLOCATE, $urandom());
      else send_request(OP_LOOKUP, probe_handle());
    end
  endtask

  task automatic test_pool_full();
    while (!(free_depth == 0 && high_water == POOL_SLOTS)) begin
      if ($urandom_range(0, 31) == 0) send_request(OP_LOOKUP, probe_handle());
      else send_request(OP_ALLOCATE, $urandom());
    end
    repeat (3) send_request(OP_ALLOCATE, $urandom());
    repeat (2) send_request(OP_RELEASE, pick_live());
    repeat (3) send_request(OP_ALLOCATE, $urandom());
    send_request(OP_LOOKUP, pick_live());
  endtask

  task automatic test_drain(input int count);
    int pick;
    for (int n = 0; n < count && live_handles.size() > 0; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) send_request(OP_RELEASE, pick_live());
      else if (pick < 9) send_request(OP_LOOKUP, probe_handle());
      else send_request(OP_RELEASE, probe_handle());
    end
    repeat (4) send_request(OP_LOOKUP, probe_handle());
  endtask

  initial begin
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.operation = OP_ALLOCATE;
    req.handle    = '0;
    idle_on       = 1'b1;
    hold_requests = 0;
    errors        = 0;
    tag_wraps     = 0;
    n_requests    = 0;
    n_ok          = 0;
    n_full        = 0;
    n_invalid     = 0;
    free_depth    = 0;
    high_water    = 0;
    tag_seq       = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_mix(30);
    test_backpressure();
    test_pool_full();
    idle_on = 1'b0;
    test_drain(30);
    test_random_mix(20);

    @(negedge clk);
    req.valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d requests: %0d ok, %0d pool full, %0d not valid",
             n_requests, n_ok, n_full, n_invalid);
    $display("pool filled to %0d slots, tag counter wrapped %0d time(s), %0d mismatches",
             high_water, tag_wraps, errors);
    if (errors == 0) begin
      $display("generational_handle_allocator_unit_tb passed");
    end else begin
      $display("generational_handle_allocator_unit_tb failed");
    end
    $finish;
  end

endmodule
